>>> hdl/tcpoax_pkg.sv
`timescale 1ns / 1ps

package tcpoax_pkg;

   // walk phases
   localparam int PHASE_W = 2;
   localparam logic [PHASE_W-1:0] PHASE_KIND = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_LEN  = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_BODY = 2'd2;

   // option kinds with fixed meaning
   localparam logic [7:0] KIND_END  = 8'd0;
   localparam logic [7:0] KIND_NOOP = 8'd1;

   localparam logic [7:0] MIN_OPT_LEN  = 8'd2;
   localparam logic [5:0] ADDR_OPT_MIN = 6'd7;

   // body offsets of the version byte and the address bytes
   localparam logic [7:0] OFS_VERSION    = 8'd2;
   localparam logic [7:0] OFS_ADDR_FIRST = 8'd3;
   localparam logic [7:0] OFS_ADDR_LAST  = 8'd6;

   // register map
   localparam int ADDR_W = 4;
   localparam logic [1:0] REG_MATCH_KIND    = 2'd0;
   localparam logic [1:0] REG_MATCH_VERSION = 2'd1;
   localparam logic [1:0] REG_MATCH_LENGTH  = 2'd2;

   localparam logic [7:0] MATCH_KIND_RST    = 8'd254;
   localparam logic [7:0] MATCH_VERSION_RST = 8'd0;
   localparam logic [5:0] MATCH_LENGTH_RST  = 6'd8;

   typedef struct packed {
      logic [7:0] match_kind;
      logic [7:0] match_version;
      logic [5:0] match_length;
   } cfg_type;

   typedef struct packed {
      logic               emit;
      logic               found;
      logic [31:0]        client_ip;
      logic [PHASE_W-1:0] phase;
      logic               decided;
   } walk_out_type;

endpackage

>>> hdl/tcpoax_walk.sv
`timescale 1ns / 1ps

module tcpoax_walk (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [7:0]                 opt_byte,
   input  logic                       last_byte,
   input  tcpoax_pkg::cfg_type        cfg,
   output tcpoax_pkg::walk_out_type   walk_out
);

   logic [tcpoax_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [7:0]  kind_ff, kind_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  ofs_ff, ofs_in;
   logic        cand_ff, cand_in;
   logic [31:0] latch_ff, latch_in;
   logic        decided_ff, decided_in;

   logic        emit;
   logic        hit;
   logic        restart;
   logic        cand_body;
   logic [31:0] latch_body;
   logic        opt_end;

   // body byte handling: version check and address shift
   always_comb begin
      cand_body  = cand_ff;
      latch_body = latch_ff;
      if (cand_ff) begin
         if (ofs_ff == tcpoax_pkg::OFS_VERSION) begin
            if (opt_byte != cfg.match_version) begin
               cand_body = 1'b0;
            end
         end else if (ofs_ff >= tcpoax_pkg::OFS_ADDR_FIRST &&
                      ofs_ff <= tcpoax_pkg::OFS_ADDR_LAST) begin
            latch_body = {latch_ff[23:0], opt_byte};
         end
      end
   end

   assign opt_end = ({1'b0, ofs_ff} + 9'd1) == {1'b0, len_ff};

   always_comb begin
      phase_in   = phase_ff;
      kind_in    = kind_ff;
      len_in     = len_ff;
      ofs_in     = ofs_ff;
      cand_in    = cand_ff;
      latch_in   = latch_ff;
      decided_in = decided_ff;
      emit       = 1'b0;
      hit        = 1'b0;
      restart    = last_byte;

      if (decided_ff) begin
         // bytes after a decision only wait for the end of the area
      end else begin
         case (phase_ff)
            tcpoax_pkg::PHASE_KIND: begin
               if (opt_byte == tcpoax_pkg::KIND_END) begin
                  emit       = 1'b1;
                  decided_in = 1'b1;
               end else begin
                  if (opt_byte != tcpoax_pkg::KIND_NOOP) begin
                     kind_in  = opt_byte;
                     phase_in = tcpoax_pkg::PHASE_LEN;
                  end
                  emit = last_byte;
               end
            end
            tcpoax_pkg::PHASE_LEN: begin
               len_in = opt_byte;
               if (opt_byte < tcpoax_pkg::MIN_OPT_LEN) begin
                  emit       = 1'b1;
                  decided_in = 1'b1;
               end else if (opt_byte == tcpoax_pkg::MIN_OPT_LEN) begin
                  phase_in = tcpoax_pkg::PHASE_KIND;
                  emit     = last_byte;
               end else begin
                  cand_in  = (kind_ff == cfg.match_kind) &&
                             (opt_byte == {2'b00, cfg.match_length}) &&
                             (cfg.match_length >= tcpoax_pkg::ADDR_OPT_MIN);
                  ofs_in   = tcpoax_pkg::MIN_OPT_LEN;
                  phase_in = tcpoax_pkg::PHASE_BODY;
                  emit     = last_byte;
               end
            end
            tcpoax_pkg::PHASE_BODY: begin
               cand_in  = cand_body;
               latch_in = latch_body;
               if (opt_end) begin
                  if (cand_body) begin
                     emit       = 1'b1;
                     hit        = 1'b1;
                     decided_in = 1'b1;
                  end else begin
                     phase_in = tcpoax_pkg::PHASE_KIND;
                     cand_in  = 1'b0;
                     emit     = last_byte;
                  end
               end else if (last_byte) begin
                  emit = 1'b1;
               end else begin
                  ofs_in = ofs_ff + 8'd1;
               end
            end
            default: begin
               phase_in = tcpoax_pkg::PHASE_KIND;
            end
         endcase
      end

      // the marked last byte always returns the walk to its start
      if (restart) begin
         phase_in   = tcpoax_pkg::PHASE_KIND;
         kind_in    = 8'd0;
         len_in     = 8'd0;
         ofs_in     = 8'd0;
         cand_in    = 1'b0;
         latch_in   = 32'd0;
         decided_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= tcpoax_pkg::PHASE_KIND;
         kind_ff    <= 8'd0;
         len_ff     <= 8'd0;
         ofs_ff     <= 8'd0;
         cand_ff    <= 1'b0;
         latch_ff   <= 32'd0;
         decided_ff <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         kind_ff    <= kind_in;
         len_ff     <= len_in;
         ofs_ff     <= ofs_in;
         cand_ff    <= cand_in;
         latch_ff   <= latch_in;
         decided_ff <= decided_in;
      end
   end

   assign walk_out.emit      = emit;
   assign walk_out.found     = hit;
   assign walk_out.client_ip = hit ? latch_body : 32'd0;
   assign walk_out.phase     = phase_ff;
   assign walk_out.decided   = decided_ff;

endmodule

>>> hdl/tcp_option_address_extractor_unit.sv
`timescale 1ns / 1ps

// channel   direction  ports                              payload
// req       in         req_valid / req_ready              req_opt_byte, req_last_byte
// rsp       out        rsp_valid / rsp_ready              rsp_found, rsp_client_ip
// csr       in         csr_psel/penable/pwrite/pready     csr_paddr, csr_pwdata, csr_prdata
//
// One option byte is taken every cycle while req_ready is high; the walk state
// updates at the accepting edge and a result goes to the output register that
// drives rsp, or to the skid register behind it while one result waits there,
// which keeps req open; req_ready drops only when both registers hold a beat.
// Reset (synchronous) restores the registers to their defaults and the walk to
// the start of an area.

module tcp_option_address_extractor_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_opt_byte,
   input  logic                          req_last_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   output logic [31:0]                   rsp_client_ip,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tcpoax_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   tcpoax_pkg::cfg_type      cfg_ff;
   tcpoax_pkg::walk_out_type walk_out;

   logic        req_fire;
   logic        csr_wr;
   logic        push;
   logic [1:0]  reg_sel;

   logic        rsp_valid_ff;
   logic        rsp_found_ff;
   logic [31:0] rsp_ip_ff;
   logic        skid_valid_ff;
   logic        skid_found_ff;
   logic [31:0] skid_ip_ff;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.match_kind    <= tcpoax_pkg::MATCH_KIND_RST;
         cfg_ff.match_version <= tcpoax_pkg::MATCH_VERSION_RST;
         cfg_ff.match_length  <= tcpoax_pkg::MATCH_LENGTH_RST;
      end else if (csr_wr) begin
         case (reg_sel)
            tcpoax_pkg::REG_MATCH_KIND:    cfg_ff.match_kind    <= csr_pwdata[7:0];
            tcpoax_pkg::REG_MATCH_VERSION: cfg_ff.match_version <= csr_pwdata[7:0];
            tcpoax_pkg::REG_MATCH_LENGTH:  cfg_ff.match_length  <= csr_pwdata[5:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         tcpoax_pkg::REG_MATCH_KIND:    csr_prdata = {24'd0, cfg_ff.match_kind};
         tcpoax_pkg::REG_MATCH_VERSION: csr_prdata = {24'd0, cfg_ff.match_version};
         tcpoax_pkg::REG_MATCH_LENGTH:  csr_prdata = {26'd0, cfg_ff.match_length};
         default:                       csr_prdata = 32'd0;
      endcase
   end

   assign req_ready = ~skid_valid_ff;
   assign req_fire  = req_valid & req_ready;

   tcpoax_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .step      (req_fire),
      .opt_byte  (req_opt_byte),
      .last_byte (req_last_byte),
      .cfg       (cfg_ff),
      .walk_out  (walk_out)
   );

   assign push = req_fire & walk_out.emit;

   // output register with one skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (~rsp_valid_ff | rsp_ready) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (~rsp_valid_ff | rsp_ready) begin
         if (skid_valid_ff) begin
            rsp_found_ff <= skid_found_ff;
            rsp_ip_ff    <= skid_ip_ff;
         end else begin
            rsp_found_ff <= walk_out.found;
            rsp_ip_ff    <= walk_out.client_ip;
         end
      end else if (push) begin
         skid_found_ff <= walk_out.found;
         skid_ip_ff    <= walk_out.client_ip;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_client_ip = rsp_ip_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held while output register empty");

   a_miss_zero_ip: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_client_ip == 32'd0))
      else $error("not-found beat carries a nonzero address");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_last_byte) |=>
         (walk_out.phase == tcpoax_pkg::PHASE_KIND && !walk_out.decided))
      else $error("walk not restarted after last byte of area");

   a_decided_silent: assert property (@(posedge clock) disable iff (reset)
      walk_out.decided |-> !walk_out.emit)
      else $error("second result within one area");

endmodule
